@@ rtl/core/fue_pkg.sv @@
package fue_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned IDX_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG    = 8'h21;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0       = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9       = 8'h39;
    localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
    localparam logic [BYTE_W-1:0] CH_UA      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UD      = 8'h44;
    localparam logic [BYTE_W-1:0] CH_UZ      = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LA      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ      = 8'h7A;

    localparam logic [IDX_W-1:0] IDX_ESC_LAST  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_CRLF_LAST = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } sel_t;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] v;
        v = {4'd0, nib};
        return (nib < 4'd10) ? (CH_0 + v) : (CH_UA + v - 8'd10);
    endfunction

endpackage

@@ rtl/core/fue_char_sel.sv @@
module fue_char_sel (
    input  logic [fue_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_mark,
    input  logic [fue_pkg::IDX_W-1:0]  idx,
    output fue_pkg::sel_t              sel
);

    always_comb begin
        sel.ch   = fue_pkg::CH_NUL;
        sel.last = 1'b1;
        if (end_mark) begin
            sel.ch   = fue_pkg::CH_NUL;
            sel.last = 1'b1;
        end else if (in_byte == fue_pkg::CH_SPACE) begin
            sel.ch = fue_pkg::CH_PLUS;
        end else if (in_byte inside {[fue_pkg::CH_0:fue_pkg::CH_9],
                                     [fue_pkg::CH_UA:fue_pkg::CH_UZ],
                                     [fue_pkg::CH_LA:fue_pkg::CH_LZ],
                                     fue_pkg::CH_AT, fue_pkg::CH_DOLLAR,
                                     fue_pkg::CH_DASH, fue_pkg::CH_UNDER,
                                     fue_pkg::CH_DOT, fue_pkg::CH_BANG,
                                     fue_pkg::CH_STAR, fue_pkg::CH_LPAREN,
                                     fue_pkg::CH_RPAREN, fue_pkg::CH_COMMA}) begin
            sel.ch = in_byte;
        end else if (in_byte == fue_pkg::CH_CR || in_byte == fue_pkg::CH_LF) begin
            // cr or lf each expand to the full crlf escape
            sel.last = (idx == fue_pkg::IDX_CRLF_LAST);
            case (idx)
                3'd0, 3'd3: sel.ch = fue_pkg::CH_PERCENT;
                3'd1, 3'd4: sel.ch = fue_pkg::CH_0;
                3'd2:       sel.ch = fue_pkg::CH_UD;
                3'd5:       sel.ch = fue_pkg::CH_UA;
                default:    sel.ch = fue_pkg::CH_NUL;
            endcase
        end else begin
            sel.last = (idx == fue_pkg::IDX_ESC_LAST);
            case (idx)
                3'd0:    sel.ch = fue_pkg::CH_PERCENT;
                3'd1:    sel.ch = fue_pkg::hex_digit(in_byte[7:4]);
                3'd2:    sel.ch = fue_pkg::hex_digit(in_byte[3:0]);
                default: sel.ch = fue_pkg::CH_NUL;
            endcase
        end
    end

endmodule

@@ rtl/core/form_url_encoder.sv @@
// channel  direction  ports                                     beats
// s_       in         s_valid s_ready s_in_byte s_end_mark      one per source byte or end
// m_       out        m_valid m_ready m_out_byte m_run_last     one per encoded character
//                     m_out_length
//
// one result beat per cycle while m_ready is high and source beats keep coming;
// a source byte gives 1, 3 or 6 characters by its encoding (1 for space, plain characters and end,
// 3 for a hex escape, 6 for cr or lf) as the escape index counter walks the held byte
// an input beat is registered in the held byte, each character in the result register
// aresetn clears the valid flags, the escape index and the character count
// m_ready low holds the result register and the held byte; s_ready falls with them
module form_url_encoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fue_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                        s_end_mark,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fue_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_run_last,
    output logic [fue_pkg::COUNT_W-1:0] m_out_length
);

    logic                        item_valid_reg, item_valid_next;
    logic [fue_pkg::BYTE_W-1:0]  item_byte_reg;
    logic                        item_end_reg;
    logic [fue_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [fue_pkg::COUNT_W-1:0] count_reg, count_next, count_inc;
    logic                        out_valid_reg, out_valid_next;
    logic [fue_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        out_last_reg;
    logic [fue_pkg::COUNT_W-1:0] out_length_reg;
    logic                        load;
    logic                        s_fire;
    fue_pkg::sel_t               sel;

    fue_char_sel u_char_sel (
        .in_byte  (item_byte_reg),
        .end_mark (item_end_reg),
        .idx      (idx_reg),
        .sel      (sel)
    );

    assign load    = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || (load && sel.last);
    assign s_fire  = s_valid && s_ready;

    assign count_inc = (count_reg == fue_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 16'd1;

    always_comb begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
            count_next     = item_end_reg ? '0 : count_inc;
            if (sel.last) begin
                item_valid_next = 1'b0;
                idx_next        = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (s_fire) begin
            item_valid_next = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_byte_reg <= s_in_byte;
            item_end_reg  <= s_end_mark;
        end
        if (load) begin
            out_byte_reg   <= sel.ch;
            out_last_reg   <= sel.last;
            // terminator carries the total without counting itself
            out_length_reg <= item_end_reg ? count_reg : count_inc;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_run_last   = out_last_reg;
    assign m_out_length = out_length_reg;

endmodule
